@@ rtl/bpfa_pkg.sv @@
// Package for the bitmap page frame allocator.
// Shared op, status and unit mode codes plus the byte unit control/result types.
// No dependencies.
package bpfa_pkg;

  // request ops
  localparam logic [1:0] OP_FREE  = 2'd0;
  localparam logic [1:0] OP_LOCK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_ALLOC = 2'd3;

  // result status
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // byte unit modes
  localparam logic [1:0] MODE_RANGE = 2'd0;  // set or clear a masked span
  localparam logic [1:0] MODE_FIND  = 2'd1;  // extend a run of free frames
  localparam logic [1:0] MODE_FREE  = 2'd2;  // first free frame

  localparam logic [7:0]  BYTE_ONES = 8'hff;
  localparam logic [7:0]  BYTE_LSB  = 8'b00000001;
  localparam logic [16:0] COUNT_MAX = 17'h1ffff;

  typedef struct packed {
    logic [1:0] mode;
    logic       set_val;
    logic       first;     // row holds the span start
    logic       last;      // row holds the span end
    logic [2:0] lo_bit;
    logic [2:0] last_bit;
  } unit_ctl_t;

  typedef struct packed {
    logic [7:0] wr_data;
    logic [3:0] nchg;
    logic       hit;
    logic [2:0] pos;
  } unit_res_t;

endpackage

@@ rtl/bitmap_page_frame_allocator_core.sv @@
// Top level of the bitmap page frame allocator: sequencer, counts and hint.
// Uses bpfa_pkg, bpfa_byte_unit (shared row unit) and bpfa_map_ram (bitmap).
// Requests come in by start/busy; each result is a one-cycle done strobe.
//
// Keeps one used bit per frame in a byte-wide RAM (eight frames a row), free
// and used counters and a next-fit hint. After reset a clearing pass writes
// every row to all-used, one row a cycle over ceil(NUM_FRAMES/8) rows (8192
// at the default), with busy high; config writes are taken throughout. An item
// is accepted when start is high and busy is low; busy stays high until the
// result is out. The result appears for exactly one cycle with done high and
// is not held: the receiver cannot stall it, so it must take it on that
// cycle. free_frames and used_frames are live counter values and hold until
// the next item changes them. Every op goes through the single RAM port pair;
// free, lock and allocate also go through the one byte unit, a row at a time:
//   query            reads the frame's row, then reports the bit
//   free / lock      read then write for each map row the range touches;
//                    ends at decode when the count is zero or the first
//                    frame is out of range
//   allocate         scans rows from the hint (one row a cycle), reads and
//                    writes each row of the run, then scans again for the
//                    new hint; a failed search ends after its scan, a zero
//                    count or a hint at the bound ends at decode
// The total_frames register (cfg_data, when cfg_valid) is always ready and
// must only be written while the block is idle.
module bitmap_page_frame_allocator_core import bpfa_pkg::*; #(
  parameter int NUM_FRAMES = 65536,
  parameter int MAX_RUN    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [15:0] frame,
  input  logic [8:0]  count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] frame_out,
  output logic        is_used,
  output logic [16:0] free_frames,
  output logic [16:0] used_frames
);

  localparam int IW    = $clog2(NUM_FRAMES);          // frame index bits
  localparam int CW    = (IW + 1 > 17) ? IW + 1 : 17; // frame arithmetic bits
  localparam int ROWS  = (NUM_FRAMES + 7) / 8;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = $clog2(MAX_RUN + 1);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_RNG_INIT = 4'd3;
  localparam logic [3:0] S_RMW_RD   = 4'd4;
  localparam logic [3:0] S_RMW_WR   = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_QRD      = 4'd7;
  localparam logic [3:0] S_QWAIT    = 4'd8;

  // control registers
  logic [3:0]       state, state_next;
  logic             done_q, done_next;
  logic [16:0]      tot_q;
  logic [IW-1:0]    hint, hint_next;
  logic [16:0]      free_q, free_next;
  logic [16:0]      used_q, used_next;
  logic [RW-1:0]    row_q, row_next;
  logic             pr_vld, pr_vld_next;
  logic             rd_stop, rd_stop_next;

  // item payload and work registers
  logic [1:0]       op_q;
  logic [15:0]      frame_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CW-1:0]    rng_lo, rng_lo_next;
  logic [CW-1:0]    rng_last, rng_last_next;
  logic [RW-1:0]    pr_row, pr_row_next;
  logic [CNT_W-1:0] run_q, run_next;
  logic             scan_free, scan_free_next;
  logic [1:0]       status_q, status_next;
  logic [15:0]      fout_q, fout_next;
  logic             ubit_q, ubit_next;

  // RAM and unit hookup
  logic             rd_en;
  logic [RW-1:0]    rd_addr;
  logic [7:0]       rd_data;
  logic             wr_en;
  logic [RW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  unit_ctl_t        ctl;
  unit_res_t        res;
  logic [CNT_W-1:0] run_out;

  // frame arithmetic
  logic [CW-1:0]    tf_w;
  logic [CW-1:0]    lim;
  logic [CW-1:0]    lim_m1;
  logic [CW-1:0]    hint_w;
  logic [CW-1:0]    frame_w;
  logic [CW-1:0]    end_m1;
  logic [CW-1:0]    base_pos;
  logic [CW-1:0]    start_f;
  logic [RW-1:0]    lo_row;
  logic [RW-1:0]    last_row;
  logic             oor;
  logic [16:0]      nchg_w;
  logic [16:0]      dec_free, dec_used;
  logic [17:0]      sum_free, sum_used;

  bpfa_map_ram #(.ROWS(ROWS), .RW(RW)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bpfa_byte_unit #(.CNT_W(CNT_W)) u_unit (
    .ctl     (ctl),
    .data    (rd_data),
    .run_in  (run_q),
    .cnt     (cnt_q),
    .res     (res),
    .run_out (run_out)
  );

  // bound is min(total_frames, NUM_FRAMES)
  always_comb begin
    tf_w     = CW'(tot_q);
    lim      = (tf_w > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : tf_w;
    lim_m1   = lim - CW'(1);
    hint_w   = CW'(hint);
    frame_w  = CW'(frame_q);
    end_m1   = frame_w + CW'(cnt_q) - CW'(1);
    oor      = (end_m1 >= lim);
    base_pos = CW'({pr_row, res.pos});
    start_f  = base_pos + CW'(1) - CW'(cnt_q);
    lo_row   = rng_lo[RW+2:3];
    last_row = rng_last[RW+2:3];
  end

  // unit control: span is [rng_lo, rng_last], processed row is pr_row
  always_comb begin
    if (state == S_SCAN) begin
      ctl.mode = scan_free ? MODE_FREE : MODE_FIND;
    end else begin
      ctl.mode = MODE_RANGE;
    end
    ctl.set_val  = (op_q != OP_FREE);
    ctl.first    = (pr_row == lo_row);
    ctl.last     = (pr_row == last_row);
    ctl.lo_bit   = rng_lo[2:0];
    ctl.last_bit = rng_last[2:0];
  end

  // saturating counter updates for the changed frames of one row
  always_comb begin
    nchg_w   = 17'(res.nchg);
    dec_free = (free_q > nchg_w) ? (free_q - nchg_w) : '0;
    dec_used = (used_q > nchg_w) ? (used_q - nchg_w) : '0;
    sum_free = 18'(free_q) + 18'(nchg_w);
    sum_used = 18'(used_q) + 18'(nchg_w);
  end

  always_comb begin
    state_next     = state;
    done_next      = 1'b0;
    hint_next      = hint;
    free_next      = free_q;
    used_next      = used_q;
    row_next       = row_q;
    pr_vld_next    = pr_vld;
    rd_stop_next   = rd_stop;
    rng_lo_next    = rng_lo;
    rng_last_next  = rng_last;
    pr_row_next    = pr_row;
    run_next       = run_q;
    scan_free_next = scan_free;
    status_next    = status_q;
    fout_next      = fout_q;
    ubit_next      = ubit_q;
    rd_en          = 1'b0;
    rd_addr        = row_q;
    wr_en          = 1'b0;
    wr_addr        = pr_row;
    wr_data        = res.wr_data;

    case (state)
      S_CLR: begin
        wr_en    = 1'b1;
        wr_addr  = row_q;
        wr_data  = BYTE_ONES;
        row_next = row_q + 1'b1;
        if (row_q == RW'(ROWS - 1)) begin
          row_next   = '0;
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        status_next = ST_DONE;
        fout_next   = '0;
        ubit_next   = 1'b0;
        case (op_q)
          OP_FREE, OP_LOCK: begin
            if (cnt_q == '0) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else begin
              status_next = oor ? ST_RANGE : ST_DONE;
              if (frame_w >= lim) begin
                done_next  = 1'b1;
                state_next = S_IDLE;
              end else begin
                rng_lo_next   = frame_w;
                rng_last_next = oor ? lim_m1 : end_m1;
                state_next    = S_RNG_INIT;
              end
            end
          end
          OP_QUERY: begin
            if (frame_w >= lim) begin
              status_next = ST_RANGE;
              ubit_next   = 1'b1;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              row_next   = frame_w[RW+2:3];
              state_next = S_QRD;
            end
          end
          default: begin
            // allocate: run search from the hint up to the bound
            if (cnt_q == '0 || hint_w >= lim) begin
              status_next = ST_NOMEM;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              rng_lo_next    = hint_w;
              rng_last_next  = lim_m1;
              row_next       = hint_w[RW+2:3];
              run_next       = '0;
              pr_vld_next    = 1'b0;
              rd_stop_next   = 1'b0;
              scan_free_next = 1'b0;
              state_next     = S_SCAN;
            end
          end
        endcase
      end

      S_RNG_INIT: begin
        row_next   = lo_row;
        state_next = S_RMW_RD;
      end

      S_RMW_RD: begin
        rd_en       = 1'b1;
        pr_row_next = row_q;
        state_next  = S_RMW_WR;
      end

      S_RMW_WR: begin
        wr_en = 1'b1;
        if (ctl.set_val) begin
          free_next = dec_free;
          used_next = sum_used[17] ? COUNT_MAX : sum_used[16:0];
        end else begin
          free_next = sum_free[17] ? COUNT_MAX : sum_free[16:0];
          used_next = dec_used;
        end
        if (ctl.last) begin
          if (op_q == OP_ALLOC) begin
            // run marked: look again from the old hint for a free frame
            rng_lo_next    = hint_w;
            rng_last_next  = lim_m1;
            row_next       = hint_w[RW+2:3];
            pr_vld_next    = 1'b0;
            rd_stop_next   = 1'b0;
            scan_free_next = 1'b1;
            state_next     = S_SCAN;
          end else begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          row_next   = row_q + 1'b1;
          state_next = S_RMW_RD;
        end
      end

      S_SCAN: begin
        // stream one row read per cycle, the unit works on the previous one
        if (!rd_stop) begin
          rd_en        = 1'b1;
          row_next     = row_q + 1'b1;
          pr_row_next  = row_q;
          pr_vld_next  = 1'b1;
          rd_stop_next = (row_q == last_row);
        end else begin
          pr_vld_next = 1'b0;
        end
        if (pr_vld) begin
          if (!scan_free) begin
            run_next = run_out;
            if (res.hit) begin
              rng_lo_next   = start_f;
              rng_last_next = base_pos;
              fout_next     = start_f[15:0];
              pr_vld_next   = 1'b0;
              state_next    = S_RNG_INIT;
            end else if (ctl.last) begin
              status_next = ST_NOMEM;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end else begin
            if (res.hit) begin
              hint_next  = IW'(base_pos);
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (ctl.last) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end

      S_QRD: begin
        rd_en      = 1'b1;
        state_next = S_QWAIT;
      end

      S_QWAIT: begin
        ubit_next  = |(rd_data & (BYTE_LSB << frame_q[2:0]));
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      done_q  <= 1'b0;
      tot_q   <= 17'd65536;
      hint    <= '0;
      free_q  <= '0;
      used_q  <= '0;
      row_q   <= '0;
      pr_vld  <= 1'b0;
      rd_stop <= 1'b0;
    end else begin
      state   <= state_next;
      done_q  <= done_next;
      hint    <= hint_next;
      free_q  <= free_next;
      used_q  <= used_next;
      row_q   <= row_next;
      pr_vld  <= pr_vld_next;
      rd_stop <= rd_stop_next;
      if (cfg_valid) begin
        tot_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q    <= op;
      frame_q <= frame;
      cnt_q   <= (int'(count) > MAX_RUN) ? CNT_W'(MAX_RUN) : CNT_W'(count);
    end
    rng_lo    <= rng_lo_next;
    rng_last  <= rng_last_next;
    pr_row    <= pr_row_next;
    run_q     <= run_next;
    scan_free <= scan_free_next;
    status_q  <= status_next;
    fout_q    <= fout_next;
    ubit_q    <= ubit_next;
  end

  assign busy        = (state != S_IDLE);
  assign cfg_ready   = 1'b1;
  assign done        = done_q;
  assign status      = status_q;
  assign frame_out   = fout_q;
  assign is_used     = ubit_q;
  assign free_frames = free_q;
  assign used_frames = used_q;

  // a result only comes out once the sequencer is back at rest
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted item always starts work on the next cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but sequencer stayed idle");

  // every result follows a busy period
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without work");

  // a run start is reported only for a successful allocate
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_DONE) |-> (frame_out == 16'd0))
    else $error("frame_out set on a failed item");

endmodule

@@ rtl/bpfa_byte_unit.sv @@
// Shared byte unit: works on one 8-frame map row per use.
// Range set/clear with change count, free-run search step, first-free search.
// Depends on bpfa_pkg.
module bpfa_byte_unit import bpfa_pkg::*; #(
  parameter int CNT_W = 9
) (
  input  unit_ctl_t        ctl,
  input  logic [7:0]       data,
  input  logic [CNT_W-1:0] run_in,
  input  logic [CNT_W-1:0] cnt,
  output unit_res_t        res,
  output logic [CNT_W-1:0] run_out
);

  logic [7:0]       lo_mask;
  logic [7:0]       hi_mask;
  logic [7:0]       act;
  logic [7:0]       wr;
  logic [7:0]       chg;
  logic [3:0]       nchg;
  logic [CNT_W-1:0] run;
  logic             find_hit;
  logic [2:0]       find_pos;
  logic             free_hit;
  logic [2:0]       free_pos;

  always_comb begin
    lo_mask = ctl.first ? (BYTE_ONES << ctl.lo_bit) : BYTE_ONES;
    hi_mask = ctl.last ? (BYTE_ONES >> (3'd7 - ctl.last_bit)) : BYTE_ONES;
    act     = lo_mask & hi_mask;
    wr      = ctl.set_val ? (data | act) : (data & ~act);
    chg     = wr ^ data;
    nchg    = '0;
    for (int k = 0; k < 8; k++) begin
      nchg = nchg + {3'b000, chg[k]};
    end

    // run grows on free frames, restarts on used ones, stops at the target
    run      = run_in;
    find_hit = 1'b0;
    find_pos = '0;
    for (int k = 0; k < 8; k++) begin
      if (act[k] && !find_hit) begin
        if (data[k]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == cnt) begin
            find_hit = 1'b1;
            find_pos = 3'(k);
          end
        end
      end
    end

    free_hit = 1'b0;
    free_pos = '0;
    for (int k = 0; k < 8; k++) begin
      if (act[k] && !data[k] && !free_hit) begin
        free_hit = 1'b1;
        free_pos = 3'(k);
      end
    end
  end

  always_comb begin
    res.wr_data = wr;
    res.nchg    = nchg;
    run_out     = run;
    case (ctl.mode)
      MODE_FIND: begin
        res.hit = find_hit;
        res.pos = find_pos;
      end
      MODE_FREE: begin
        res.hit = free_hit;
        res.pos = free_pos;
      end
      default: begin
        res.hit = 1'b0;
        res.pos = '0;
      end
    endcase
  end

endmodule

@@ rtl/bpfa_map_ram.sv @@
// Frame bitmap storage, one byte row holds eight frames.
// One write port and one read port with registered read data.
// Depends on bpfa_pkg.
module bpfa_map_ram import bpfa_pkg::*; #(
  parameter int ROWS = 8192,
  parameter int RW   = 13
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [RW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [RW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
